[sv/pma_pkg.sv]
// Shared types and constants of the paged memory allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package pma_pkg;

    localparam int OP_W    = 2;
    localparam int PID_W   = 4;
    localparam int SIZE_W  = 17;
    localparam int VADDR_W = 16;
    localparam int DATA_W  = 8;
    localparam int BRK_W   = 17;
    localparam int APB_AW  = 3;

    localparam logic [BRK_W-1:0] START_BREAK_RESET = 17'd256;
    localparam logic REG_IDX_START_BREAK = 1'b0;

    typedef enum logic [1:0]
    {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        RES_FAIL  = 2'd0,
        RES_OK    = 2'd1,
        RES_ALLOC = 2'd2,
        RES_READ  = 2'd3
    } res_kind_t;

    typedef struct packed
    {
        logic      clr_step;
        logic      ld_item;
        logic      map_rd;
        logic      ram_rd;
        logic      ram_wr;
        logic      free_init;
        logic      link_rd;
        logic      free_step;
        logic      scan_step;
        logic      scan_end;
        logic      rd_cap;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed
    {
        logic clr_done;
        logic pid_bad;
        logic alloc_fail;
        logic pages_zero;
        logic page_oob;
        logic map_hit;
        logic walk_done;
        logic scan_full;
        logic out_busy;
        op_t  op;
    } sts_t;

endpackage

[sv/paged_memory_allocator_mmu_top.sv]
// Top level of the paged memory allocator: stream ports, APB register port,
// controller and datapath. Depends on pma_pkg, pma_ctrl, pma_dp and pma_ram.
//
// One request is handled at a time and every request gives one result.
// After reset a clearing pass zeroes the byte RAM, page map and frame bitmap,
// one entry a cycle; no request is taken until it ends, while register writes
// are taken.
// A request that fails at decode (bad pid, no room, page out of range) or a
// zero-byte alloc goes straight to the result; an unmapped address or a write
// ends after the page map lookup, a read after the byte RAM read as well; free
// walks the chain frame by frame, and alloc scans the frame bitmap up to the
// last frame taken (at most FRAME_COUNT); each result waits for the previous one.
// Alloc scans the frame bitmap one frame a cycle; free reads the frame link
// memory, a registered read, for each frame of the chain.
// The next request is accepted while a result still waits for transfer.
module paged_memory_allocator_mmu_top
    import pma_pkg::*;
#(
    parameter int OFFSET_BITS = 8,
    parameter int FRAME_COUNT = 256,
    parameter int MAX_PID     = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // pid, alloc_size, vaddr, write_data
    input  logic [1:0]        s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // alloc_addr, read_data
    output logic              m_tuser,   // status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cmd_t              cmd;
    sts_t              sts;
    logic [BRK_W-1:0]  start_break_reg;
    logic              cfg_we;
    logic [BRK_W-1:0]  out_addr;
    logic [DATA_W-1:0] out_rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_START_BREAK);
    assign prdata = (paddr[2] == REG_IDX_START_BREAK) ? 32'(start_break_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_break_reg <= START_BREAK_RESET;
        end
        else if (cfg_we)
        begin
            start_break_reg <= pwdata[BRK_W-1:0];
        end
    end

    pma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pma_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .FRAME_COUNT (FRAME_COUNT),
        .MAX_PID     (MAX_PID)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_pid     (s_tdata[3:0]),
        .in_size    (s_tdata[20:4]),
        .in_vaddr   (s_tdata[36:21]),
        .in_wdata   (s_tdata[44:37]),
        .cfg_we     (cfg_we),
        .cfg_value  (pwdata[BRK_W-1:0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (m_tuser),
        .out_addr   (out_addr),
        .out_rdata  (out_rdata)
    );

    assign m_tdata = {7'd0, out_rdata, out_addr};

endmodule

[sv/pma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/pma_ctrl.sv]
// Sequencer of the paged memory allocator: steps one request at a time.
// Depends on pma_pkg; drives the datapath through cmd_t, watches sts_t.
module pma_ctrl
    import pma_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOOK,
        ST_FREE_ISSUE,
        ST_FREE_STEP,
        ST_RD_WAIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_DONE
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_kind = kind_reg;
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.pid_bad)
                begin
                    kind_next  = RES_FAIL;
                    state_next = ST_DONE;
                end
                else if (sts.op == OP_ALLOC)
                begin
                    if (sts.alloc_fail)
                    begin
                        kind_next  = RES_FAIL;
                        state_next = ST_DONE;
                    end
                    else if (sts.pages_zero)
                    begin
                        kind_next  = RES_ALLOC;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else if (sts.page_oob)
                begin
                    kind_next  = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.map_rd = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!sts.map_hit)
                begin
                    kind_next  = RES_FAIL;
                    state_next = ST_DONE;
                end
                else if (sts.op == OP_READ)
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_RD_WAIT;
                end
                else if (sts.op == OP_WRITE)
                begin
                    cmd.ram_wr = 1'b1;
                    kind_next  = RES_OK;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.free_init = 1'b1;
                    state_next    = ST_FREE_ISSUE;
                end
            end
            ST_FREE_ISSUE:
            begin
                cmd.link_rd = 1'b1;
                state_next  = ST_FREE_STEP;
            end
            ST_FREE_STEP:
            begin
                cmd.free_step = 1'b1;
                if (sts.walk_done)
                begin
                    kind_next  = RES_OK;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FREE_ISSUE;
                end
            end
            ST_RD_WAIT:
            begin
                cmd.rd_cap = 1'b1;
                kind_next  = RES_READ;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (sts.scan_full)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SCAN_END:
            begin
                cmd.scan_end = 1'b1;
                kind_next    = RES_ALLOC;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[sv/pma_dp.sv]
// Datapath of the paged memory allocator: frame bitmap, break pointers,
// page map, frame links, byte RAM and the result register.
// Depends on pma_pkg and pma_ram; steered by pma_ctrl through cmd_t.
module pma_dp
    import pma_pkg::*;
#(
    parameter int OFFSET_BITS = 8,
    parameter int FRAME_COUNT = 256,
    parameter int MAX_PID     = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [OP_W-1:0]    in_op,
    input  logic [PID_W-1:0]   in_pid,
    input  logic [SIZE_W-1:0]  in_size,
    input  logic [VADDR_W-1:0] in_vaddr,
    input  logic [DATA_W-1:0]  in_wdata,
    input  logic               cfg_we,
    input  logic [BRK_W-1:0]   cfg_value,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic               out_status,
    output logic [BRK_W-1:0]   out_addr,
    output logic [DATA_W-1:0]  out_rdata
);

    localparam int FB        = $clog2(FRAME_COUNT);
    localparam int FCW       = FB + 1;
    localparam int RAM_DEPTH = FRAME_COUNT << OFFSET_BITS;
    localparam int RAM_AW    = FB + OFFSET_BITS;
    localparam int MAP_DEPTH = MAX_PID * FRAME_COUNT;
    localparam int MAPW      = $clog2(MAP_DEPTH);
    localparam int PIDW      = (MAX_PID > 1) ? $clog2(MAX_PID) : 1;
    localparam int VPW       = VADDR_W - OFFSET_BITS;
    localparam int PGS_W     = SIZE_W + 1 - OFFSET_BITS;
    localparam int SUM_W     = (RAM_AW + 1 > SIZE_W + 2) ? RAM_AW + 1 : SIZE_W + 2;
    localparam int CLR_LEN   = (RAM_DEPTH > MAP_DEPTH) ? RAM_DEPTH : MAP_DEPTH;
    localparam int CLRW      = $clog2(CLR_LEN + 1);

    op_t                 op_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [VADDR_W-1:0]  va_reg;
    logic [DATA_W-1:0]   wd_reg;
    logic [MAPW-1:0]     base_reg;
    logic [BRK_W-1:0]    bp_reg;
    logic [BRK_W-1:0]    brk_reg [MAX_PID];
    logic [FCW-1:0]      free_cnt_reg;
    logic [FB:0]         page_reg;
    logic [FB-1:0]       frame_reg;
    logic [FB-1:0]       scan_reg;
    logic [FB-1:0]       prev_reg;
    logic                have_prev_reg;
    logic [FCW-1:0]      k_reg;
    logic [FB-1:0]       step_reg;
    logic [DATA_W-1:0]   rd_reg;
    logic [CLRW-1:0]     clr_reg;
    logic                out_valid_reg;
    logic                status_reg;
    logic [BRK_W-1:0]    addr_reg;
    logic [DATA_W-1:0]   rdata_reg;

    logic                pid_in_ok;
    logic [BRK_W-1:0]    bp_in;
    logic [SIZE_W:0]     size_up;
    logic [PGS_W-1:0]    pages;
    logic [SIZE_W:0]     round_sz;
    logic [SUM_W-1:0]    end_sum;
    logic [VPW-1:0]      va_page;
    logic [MAPW-1:0]     page_idx;

    logic                map_we;
    logic [MAPW-1:0]     map_waddr;
    logic [FB:0]         map_wdata;
    logic [FB:0]         map_rdata;
    logic                link_we;
    logic [FB-1:0]       link_waddr;
    logic [FB:0]         link_wdata;
    logic [FB:0]         link_rdata;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [RAM_AW-1:0]   phys;
    logic [DATA_W-1:0]   ram_rdata;
    logic                used_we;
    logic [FB-1:0]       used_waddr;
    logic                used_wdata;
    logic [FB-1:0]       used_raddr;
    logic                used_rdata;
    logic                scan_free;

    assign pid_in_ok = (in_pid != '0) && (32'(in_pid) <= MAX_PID);
    assign bp_in     = pid_in_ok ? brk_reg[PIDW'(in_pid - 1'b1)] : '0;

    // round the byte count up to whole pages
    assign size_up  = {1'b0, size_reg} + (SIZE_W+1)'((1 << OFFSET_BITS) - 1);
    assign pages    = size_up[SIZE_W:OFFSET_BITS];
    assign round_sz = {pages, {OFFSET_BITS{1'b0}}};
    assign end_sum  = SUM_W'(bp_reg) + SUM_W'(round_sz);

    assign va_page  = va_reg[VADDR_W-1:OFFSET_BITS];
    assign page_idx = base_reg + MAPW'(page_reg);
    assign phys     = {map_rdata[FB-1:0], va_reg[OFFSET_BITS-1:0]};

    // bitmap read runs one frame ahead of the scan; the walk reads its own frame
    assign used_raddr = cmd.link_rd ? frame_reg
                                    : (cmd.scan_step ? scan_reg + 1'b1 : scan_reg);
    assign scan_free  = ~used_rdata;

    always_comb
    begin
        sts.clr_done   = (clr_reg == CLRW'(CLR_LEN));
        sts.pid_bad    = (pid_reg == '0) || (32'(pid_reg) > MAX_PID);
        sts.alloc_fail = (end_sum > SUM_W'(RAM_DEPTH))
                         || (SUM_W'(pages) > SUM_W'(free_cnt_reg));
        sts.pages_zero = (pages == '0);
        sts.page_oob   = (SUM_W'(va_page) >= SUM_W'(FRAME_COUNT));
        sts.map_hit    = map_rdata[FB];
        sts.walk_done  = link_rdata[FB]
                         || (FCW'(link_rdata[FB-1:0]) >= FCW'(FRAME_COUNT))
                         || (step_reg == FB'(FRAME_COUNT - 1));
        sts.scan_full  = (SUM_W'(k_reg) == SUM_W'(pages));
        sts.out_busy   = out_valid_reg && !m_tready;
        sts.op         = op_reg;
    end

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = page_idx;
        map_wdata = '0;
        if (cmd.clr_step)
        begin
            map_we    = (32'(clr_reg) < MAP_DEPTH);
            map_waddr = clr_reg[MAPW-1:0];
        end
        else if (cmd.scan_step)
        begin
            map_we    = scan_free;
            map_wdata = {1'b1, scan_reg};
        end
        else if (cmd.free_step)
        begin
            map_we = (FCW'(page_reg) < FCW'(FRAME_COUNT)) && !page_reg[FB];
        end
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = prev_reg;
        link_wdata = {1'b1, {FB{1'b0}}};
        if (cmd.scan_step)
        begin
            link_we    = scan_free && have_prev_reg;
            link_wdata = {1'b0, scan_reg};
        end
        else if (cmd.scan_end)
        begin
            link_we = 1'b1;
        end
        else if (cmd.free_step)
        begin
            link_we    = 1'b1;
            link_waddr = frame_reg;
        end
    end

    always_comb
    begin
        used_we    = 1'b0;
        used_waddr = frame_reg;
        used_wdata = 1'b0;
        if (cmd.clr_step)
        begin
            used_we    = (32'(clr_reg) < FRAME_COUNT);
            used_waddr = clr_reg[FB-1:0];
        end
        else if (cmd.scan_step)
        begin
            used_we    = scan_free;
            used_waddr = scan_reg;
            used_wdata = 1'b1;
        end
        else if (cmd.free_step)
        begin
            used_we = 1'b1;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = phys;
        ram_wdata = wd_reg;
        if (cmd.clr_step)
        begin
            ram_we    = (32'(clr_reg) < RAM_DEPTH);
            ram_waddr = clr_reg[RAM_AW-1:0];
            ram_wdata = '0;
        end
        else if (cmd.ram_wr)
        begin
            ram_we = 1'b1;
        end
    end

    pma_ram #(.WIDTH(FB + 1), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (base_reg + MAPW'(va_page)),
        .rdata (map_rdata)
    );

    pma_ram #(.WIDTH(FB + 1), .DEPTH(FRAME_COUNT)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (frame_reg),
        .rdata (link_rdata)
    );

    pma_ram #(.WIDTH(1), .DEPTH(FRAME_COUNT)) u_used (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    pma_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_bytes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (phys),
        .rdata (ram_rdata)
    );

    // payload, read-capture and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg   <= op_t'(in_op);
            pid_reg  <= in_pid;
            size_reg <= in_size;
            va_reg   <= in_vaddr;
            wd_reg   <= in_wdata;
            base_reg <= MAPW'((32'(in_pid) - 32'd1) * FRAME_COUNT);
            bp_reg   <= bp_in;
        end
        if (cmd.rd_cap)
        begin
            rd_reg <= ram_rdata;
        end
        if (cmd.res_load)
        begin
            status_reg <= (cmd.res_kind == RES_FAIL);
            addr_reg   <= (cmd.res_kind == RES_ALLOC) ? bp_reg : '0;
            rdata_reg  <= (cmd.res_kind == RES_READ) ? rd_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg  <= FCW'(FRAME_COUNT);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            page_reg      <= '0;
            frame_reg     <= '0;
            scan_reg      <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
            for (int p = 0; p < MAX_PID; p++)
            begin
                brk_reg[p] <= START_BREAK_RESET;
            end
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                for (int p = 0; p < MAX_PID; p++)
                begin
                    brk_reg[p] <= cfg_value;
                end
            end
            if (cmd.ld_item)
            begin
                page_reg      <= (FB+1)'(bp_in >> OFFSET_BITS);
                scan_reg      <= '0;
                have_prev_reg <= 1'b0;
                k_reg         <= '0;
                step_reg      <= '0;
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (scan_free)
                begin
                    free_cnt_reg  <= free_cnt_reg - 1'b1;
                    k_reg         <= k_reg + 1'b1;
                    prev_reg      <= scan_reg;
                    have_prev_reg <= 1'b1;
                    page_reg      <= page_reg + 1'b1;
                end
            end
            if (cmd.scan_end)
            begin
                brk_reg[PIDW'(pid_reg - 1'b1)] <= BRK_W'(end_sum);
            end
            if (cmd.free_init)
            begin
                frame_reg <= map_rdata[FB-1:0];
                page_reg  <= (FB+1)'(va_page);
            end
            if (cmd.free_step)
            begin
                // release whatever the owner; count only frames that were taken
                free_cnt_reg <= free_cnt_reg + FCW'(used_rdata);
                frame_reg    <= link_rdata[FB-1:0];
                page_reg     <= page_reg + 1'b1;
                step_reg     <= step_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = status_reg;
    assign out_addr   = addr_reg;
    assign out_rdata  = rdata_reg;

`ifndef ASSERT_OFF
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_cnt_reg) <= FRAME_COUNT)
        else $error("free frame count above the number of frames");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !m_tready))
        else $error("result loaded over a transfer still pending");

    a_scan_takes_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && scan_free) |-> (free_cnt_reg != '0))
        else $error("frame taken with no free frame counted");

    a_one_ram_user: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && (cmd.ram_wr || cmd.scan_step || cmd.free_step)))
        else $error("clearing pass overlaps a request");
`endif

endmodule

[verif/tb_paged_memory_allocator_mmu_top.sv]
// Self-checking testbench for paged_memory_allocator_mmu_top: a directed table, then random
// alloc/access/free traffic, checked against a behavioral page/frame model held here.
// Depends on pma_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_paged_memory_allocator_mmu_top;
    import pma_pkg::*;

    localparam int PAGE_B    = 256;
    localparam int FRAMES    = 256;
    localparam int PIDS      = 15;
    localparam int LINK_END  = 'h8000;
    localparam int SETTLE    = 400;
    localparam int NUM_PHASE = 5;

    typedef struct packed
    {
        logic        status;
        logic [16:0] addr;
        logic [7:0]  rd;
    } mmu_res_t;

    typedef struct
    {
        op_t         op;
        logic [3:0]  pid;
        logic [16:0] size;
        logic [15:0] va;
        logic [7:0]  wd;
    } mmu_req_t;

    typedef struct
    {
        mmu_req_t req;
        bit       typed;
        mmu_res_t res;
    } dir_row_t;

    typedef struct
    {
        logic [3:0] pid;
        int         addr;
        int         pages;
    } region_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // pid, alloc_size, vaddr, write_data
    logic [1:0]        s_tuser = '0;   // op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;        // alloc_addr, read_data
    logic              m_tuser;        // status
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    paged_memory_allocator_mmu_top u_dut (.*);

    always #6 clk = ~clk;

    // Page/frame state of the expected behavior
    int          mdl_start_break;
    logic [3:0]  mdl_owner [FRAMES];
    int          mdl_link [FRAMES];
    bit          mdl_map_valid [PIDS*FRAMES];
    logic [7:0]  mdl_map_frame [PIDS*FRAMES];
    int          mdl_break [PIDS];
    logic [7:0]  mdl_ram [65536];

    mmu_res_t    pending_res [$];
    region_t     live_regions [$];
    int          errors = 0;
    int          n_ok [4] = '{0, 0, 0, 0};
    int          n_fail [4] = '{0, 0, 0, 0};
    int          n_checked = 0;

    initial
    begin
        #(12.0 * 4000000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit translate(logic [3:0] pid, int va, output int pa);
        int page;
        int idx;
        page = va >> 8;
        pa = 0;
        if (page >= FRAMES)
            return 0;
        idx = (pid - 1) * FRAMES + page;
        if (!mdl_map_valid[idx])
            return 0;
        pa = (int'(mdl_map_frame[idx]) << 8) | (va & (PAGE_B - 1));
        return 1;
    endfunction

    function automatic bit do_alloc(logic [3:0] pid, int size, output int addr);
        int pages;
        int bp;
        int free_cnt;
        int k;
        int prev;
        int first;
        int idx;
        pages = (size + PAGE_B - 1) >> 8;
        bp = mdl_break[pid-1];
        free_cnt = 0;
        k = 0;
        prev = -1;
        addr = 0;
        if (bp + pages * PAGE_B > 65536)
            return 0;
        for (int f = 0; f < FRAMES; f++)
            if (mdl_owner[f] == 0)
                free_cnt++;
        if (free_cnt < pages)
            return 0;
        addr = bp;
        if (pages == 0)
            return 1;
        first = bp >> 8;
        for (int f = 0; f < FRAMES && k < pages; f++)
        begin
            if (mdl_owner[f] != 0)
                continue;
            mdl_owner[f] = pid;
            mdl_link[f] = LINK_END;
            if (prev >= 0)
                mdl_link[prev] = f;
            prev = f;
            idx = (pid - 1) * FRAMES + first + k;
            mdl_map_valid[idx] = 1'b1;
            mdl_map_frame[idx] = f[7:0];
            k++;
        end
        mdl_break[pid-1] = bp + pages * PAGE_B;
        live_regions.push_back('{pid, bp, pages});
        if (live_regions.size() > 48)
            void'(live_regions.pop_front());
        return 1;
    endfunction

    function automatic bit do_free(logic [3:0] pid, int va);
        int pa;
        int frame;
        int nxt;
        int a;
        if (!translate(pid, va, pa))
            return 0;
        frame = pa >> 8;
        a = va;
        for (int steps = 0; steps < FRAMES; steps++)
        begin
            nxt = mdl_link[frame];
            mdl_owner[frame] = '0;
            mdl_link[frame] = LINK_END;
            if ((a >> 8) < FRAMES)
                mdl_map_valid[(pid - 1) * FRAMES + (a >> 8)] = 1'b0;
            if (nxt & LINK_END)
                break;
            frame = nxt & 'h7FFF;
            if (frame >= FRAMES)
                break;
            a += PAGE_B;
        end
        return 1;
    endfunction

    // Advance the state by one request and return what the block must answer
    function automatic mmu_res_t mmu_predict(mmu_req_t r);
        mmu_res_t res;
        int addr;
        int pa;
        bit ok;
        res = '{status: 1'b1, addr: '0, rd: '0};
        ok = 0;
        if (r.pid != 0)
        begin
            case (r.op)
                OP_ALLOC:
                begin
                    ok = do_alloc(r.pid, r.size, addr);
                    if (ok)
                        res.addr = addr[16:0];
                end
                OP_FREE:  ok = do_free(r.pid, r.va);
                default:
                begin
                    ok = translate(r.pid, r.va, pa);
                    if (ok && r.op == OP_READ)
                        res.rd = mdl_ram[pa];
                    else if (ok)
                        mdl_ram[pa] = r.wd;
                end
            endcase
        end
        res.status = !ok;
        if (ok)
            n_ok[r.op]++;
        else
            n_fail[r.op]++;
        return res;
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        mmu_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_res.size() == 0)
            begin
                $error("unexpected result transfer: status=%0d", m_tuser);
                errors++;
            end
            else
            begin
                want = pending_res.pop_front();
                n_checked++;
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[16:0] !== want.addr)
                begin
                    $error("alloc_addr: expected %0d, got %0d", want.addr, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[24:17] !== want.rd)
                begin
                    $error("read_data: expected %0d, got %0d", want.rd, m_tdata[24:17]);
                    errors++;
                end
            end
        end
    end

    // Receiver: stall pattern drawn at random from four modes, from always ready to mostly stalled
    initial
    begin
        int mode;
        int cnt;
        cnt = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (cnt % 64 == 0)
                mode = $urandom_range(0, 3);
            cnt++;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 9) < 7);
                2: m_tready = ((cnt % 8) < 2);
                default: m_tready = ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    int burst_left = 0;

    // Drive one request and hold it until the transfer
    task automatic send_req(mmu_req_t r, bit typed, mmu_res_t typed_res);
        mmu_res_t res;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = r.op;
        s_tdata = {3'b000, r.wd, r.va, r.size, r.pid};
        do
            @(posedge clk);
        while (!s_tready);
        res = mmu_predict(r);
        if (typed && res != typed_res)
        begin
            $error("table row disagrees with prediction: expected %h, predicted %h",
                   typed_res, res);
            errors++;
        end
        pending_res.push_back(typed ? typed_res : res);
    endtask

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        s_tvalid = 1'b0;
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_IDX_START_BREAK, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[16:0] !== value[16:0])
        begin
            $error("start_break: expected %0d, got %0d", value[16:0], prdata[16:0]);
            errors++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        mdl_start_break = value[16:0];
        for (int p = 0; p < PIDS; p++)
            mdl_break[p] = mdl_start_break;
    endtask

    function automatic mmu_req_t random_req();
        mmu_req_t r;
        region_t g;
        int sel;
        int pick;
        r.op = OP_ALLOC;
        r.pid = 4'($urandom_range(1, 15));
        r.size = ($urandom_range(0, 19) == 0) ? 17'($urandom_range(0, 65536))
                                               : 17'($urandom_range(0, 2200));
        r.va = 16'($urandom);
        r.wd = 8'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            // noise: anything the fields allow
            r.op = op_t'($urandom_range(0, 3));
            r.pid = 4'($urandom_range(0, 15));
            r.size = 17'($urandom_range(0, 131071));
            return r;
        end
        if (sel < 35 || live_regions.size() == 0)
            return r;
        pick = $urandom_range(0, live_regions.size() - 1);
        g = live_regions[pick];
        r.pid = g.pid;
        r.va = 16'(g.addr + $urandom_range(0, g.pages * PAGE_B - 1));
        if (sel < 55)
        begin
            r.op = OP_FREE;
            if ($urandom_range(0, 3) != 0)
                r.va = 16'(g.addr);
            live_regions.delete(pick);
        end
        else if (sel < 80)
            r.op = OP_WRITE;
        else
            r.op = OP_READ;
        return r;
    endfunction

    initial
    begin
        dir_row_t dir_rows [$];
        int phase_brk [NUM_PHASE];
        int phase_items [NUM_PHASE];
        mmu_res_t none;

        none = '0;
        for (int f = 0; f < FRAMES; f++)
        begin
            mdl_owner[f] = '0;
            mdl_link[f] = 0;
        end
        for (int i = 0; i < PIDS * FRAMES; i++)
        begin
            mdl_map_valid[i] = 1'b0;
            mdl_map_frame[i] = '0;
        end
        for (int i = 0; i < 65536; i++)
            mdl_ram[i] = '0;
        mdl_start_break = 256;
        for (int p = 0; p < PIDS; p++)
            mdl_break[p] = 256;

        dir_rows = '{
            '{'{OP_READ,  4'd1,  17'd0,     16'd256,   8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_ALLOC, 4'd0,  17'd100,   16'd0,     8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_ALLOC, 4'd1,  17'd0,     16'd0,     8'd0},   1, '{1'b0, 17'd256, 8'd0}},
            '{'{OP_ALLOC, 4'd1,  17'd1,     16'd0,     8'd0},   1, '{1'b0, 17'd256, 8'd0}},
            '{'{OP_WRITE, 4'd1,  17'd0,     16'd511,   8'hff},  1, '{1'b0, 17'd0,   8'd0}},
            '{'{OP_READ,  4'd1,  17'd0,     16'd511,   8'd0},   1, '{1'b0, 17'd0,   8'hff}},
            '{'{OP_ALLOC, 4'd15, 17'd65536, 16'd0,     8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_ALLOC, 4'd15, 17'd65280, 16'd0,     8'd0},   1, '{1'b0, 17'd256, 8'd0}},
            '{'{OP_ALLOC, 4'd2,  17'd1,     16'd0,     8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_WRITE, 4'd15, 17'd0,     16'hffff,  8'h5a},  0, none},
            '{'{OP_READ,  4'd15, 17'd0,     16'hffff,  8'd0},   0, none},
            '{'{OP_FREE,  4'd15, 17'd0,     16'h0300,  8'd0},   0, none},
            '{'{OP_READ,  4'd15, 17'd0,     16'h0300,  8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_READ,  4'd15, 17'd0,     16'h0200,  8'd0},   0, none},
            '{'{OP_ALLOC, 4'd2,  17'd513,   16'd0,     8'd0},   1, '{1'b0, 17'd256, 8'd0}},
            '{'{OP_FREE,  4'd1,  17'd0,     16'd300,   8'd0},   0, none},
            '{'{OP_WRITE, 4'd3,  17'd0,     16'hffff,  8'h81},  1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_FREE,  4'd0,  17'd0,     16'd256,   8'd0},   1, '{1'b1, 17'd0,   8'd0}},
            '{'{OP_FREE,  4'd15, 17'd0,     16'd256,   8'd0},   0, none},
            '{'{OP_READ,  4'd2,  17'd0,     16'd256,   8'd0},   0, none}
        };
        phase_brk = '{256, 0, 65536, 4133, 0};
        phase_items = '{330, 330, 60, 330, 330};
        phase_brk[4] = $urandom_range(0, 65536);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASE; ph++)
        begin
            while (pending_res.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            apb_write(phase_brk[ph]);
            if (ph == 0)
                foreach (dir_rows[i])
                    send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            for (int n = 0; n < phase_items[ph]; n++)
                send_req(random_req(), 0, none);
            @(negedge clk);
            s_tvalid = 1'b0;
        end

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Checked %0d results over %0d break settings.", n_checked, NUM_PHASE);
        $display("ok/fail: alloc %0d/%0d free %0d/%0d read %0d/%0d write %0d/%0d",
                 n_ok[OP_ALLOC], n_fail[OP_ALLOC], n_ok[OP_FREE], n_fail[OP_FREE],
                 n_ok[OP_READ], n_fail[OP_READ], n_ok[OP_WRITE], n_fail[OP_WRITE]);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
